[src/smr_pkg.sv]
`default_nettype none
package smr_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned MAX_ROWS_DEF = 8;
  localparam int unsigned MAX_COLS_DEF = 8;
  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  // read request from the spiral walker to the output buffer
  typedef struct packed {
    logic rd_en;
    logic last;
  } rd_req_t;

endpackage
`default_nettype wire

[src/smr_ram.sv]
`default_nettype none
module smr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/smr_seq.sv]
`default_nettype none
module smr_seq #(
  parameter int unsigned MAX_ROWS = smr_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = smr_pkg::MAX_COLS_DEF,
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned LW = $clog2(DEPTH + 1),
  localparam int unsigned RW = $clog2(MAX_ROWS + 1),
  localparam int unsigned CW = $clog2(MAX_COLS + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [RW-1:0]   rows,
  input  wire logic [CW-1:0]   cols,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            rd_ok,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output smr_pkg::rd_req_t     rd_req,
  output logic [AW-1:0]        rd_addr
);

  localparam int unsigned PW = RW + CW;

  smr_pkg::state_t state_r, state_nxt;
  smr_pkg::dir_t   dir_r, dir_nxt;
  logic [LW-1:0] load_cnt_r, load_cnt_nxt;
  logic [LW-1:0] n_r, n_nxt;
  logic [RW-1:0] row_r, row_nxt, top_r, top_nxt, bot_r, bot_nxt;
  logic [CW-1:0] col_r, col_nxt, lft_r, lft_nxt, rgt_r, rgt_nxt;

  logic [PW-1:0] total_full, row_base, addr_full;
  logic [LW-1:0] total, load_inc;
  logic          is_last;

  assign total_full = PW'(rows) * PW'(cols);
  assign total      = total_full[LW-1:0];
  assign load_inc   = load_cnt_r + LW'(1);
  assign row_base   = PW'(row_r) * PW'(cols);
  assign addr_full  = row_base + PW'(col_r);
  assign rd_addr    = addr_full[AW-1:0];
  assign wr_addr    = load_cnt_r[AW-1:0];
  assign is_last    = (n_r == total - LW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= smr_pkg::ST_LOAD;
      dir_r      <= smr_pkg::DIR_RIGHT;
      load_cnt_r <= '0;
      n_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      dir_r      <= dir_nxt;
      load_cnt_r <= load_cnt_nxt;
      n_r        <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
    top_r <= top_nxt;
    bot_r <= bot_nxt;
    lft_r <= lft_nxt;
    rgt_r <= rgt_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    dir_nxt      = dir_r;
    load_cnt_nxt = load_cnt_r;
    n_nxt        = n_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    top_nxt      = top_r;
    bot_nxt      = bot_r;
    lft_nxt      = lft_r;
    rgt_nxt      = rgt_r;
    in_ready     = 1'b0;
    wr_en        = 1'b0;
    rd_req.rd_en = 1'b0;
    rd_req.last  = is_last;
    unique case (state_r)
      smr_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          wr_en = 1'b1;
          if (load_inc >= total) begin
            // matrix complete, set up the first lap
            load_cnt_nxt = '0;
            state_nxt    = smr_pkg::ST_EMIT;
            dir_nxt      = smr_pkg::DIR_RIGHT;
            n_nxt        = '0;
            row_nxt      = '0;
            col_nxt      = '0;
            top_nxt      = '0;
            lft_nxt      = '0;
            bot_nxt      = rows - RW'(1);
            rgt_nxt      = cols - CW'(1);
          end else begin
            load_cnt_nxt = load_inc;
          end
        end
      end
      smr_pkg::ST_EMIT: begin
        if (rd_ok) begin
          rd_req.rd_en = 1'b1;
          n_nxt        = n_r + LW'(1);
          if (is_last) begin
            state_nxt = smr_pkg::ST_LOAD;
            dir_nxt   = smr_pkg::DIR_RIGHT;
          end
          // step along the current side, turn at its end and pull that bound in
          unique case (dir_r)
            smr_pkg::DIR_RIGHT: begin
              if (col_r < rgt_r) begin
                col_nxt = col_r + CW'(1);
              end else begin
                top_nxt = top_r + RW'(1);
                row_nxt = row_r + RW'(1);
                if (!is_last) dir_nxt = smr_pkg::DIR_DOWN;
              end
            end
            smr_pkg::DIR_DOWN: begin
              if (row_r < bot_r) begin
                row_nxt = row_r + RW'(1);
              end else begin
                rgt_nxt = rgt_r - CW'(1);
                col_nxt = col_r - CW'(1);
                if (!is_last) dir_nxt = smr_pkg::DIR_LEFT;
              end
            end
            smr_pkg::DIR_LEFT: begin
              if (col_r > lft_r) begin
                col_nxt = col_r - CW'(1);
              end else begin
                bot_nxt = bot_r - RW'(1);
                row_nxt = row_r - RW'(1);
                if (!is_last) dir_nxt = smr_pkg::DIR_UP;
              end
            end
            smr_pkg::DIR_UP: begin
              if (row_r > top_r) begin
                row_nxt = row_r - RW'(1);
              end else begin
                lft_nxt = lft_r + CW'(1);
                col_nxt = col_r + CW'(1);
                if (!is_last) dir_nxt = smr_pkg::DIR_RIGHT;
              end
            end
          endcase
        end
      end
    endcase
  end

endmodule
`default_nettype wire

[src/smr_ofifo.sv]
`default_nettype none
module smr_ofifo #(
  parameter int unsigned WIDTH = smr_pkg::DATA_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire smr_pkg::rd_req_t rd_req,
  input  wire logic [WIDTH-1:0] rd_data,
  output logic                  rd_ok,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data,
  output logic                  out_last
);

  logic             pend_r, pend_last_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             head_r, head_nxt;
  logic [WIDTH-1:0] data_r [2];
  logic             last_r [2];
  logic             pop, push, wr_idx;
  logic [1:0]       occ_after;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = data_r[head_r];
  assign out_last  = last_r[head_r];
  assign pop       = out_valid & out_ready;
  assign push      = pend_r;
  assign wr_idx    = head_r ^ cnt_r[0];

  // a read may go out only if its beat is sure to find a free slot
  assign occ_after = cnt_r + {1'b0, pend_r} - {1'b0, pop};
  assign rd_ok     = (occ_after < 2'd2);

  always_comb begin
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
    head_nxt = pop ? ~head_r : head_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      cnt_r  <= 2'd0;
      head_r <= 1'b0;
    end else begin
      pend_r <= rd_req.rd_en;
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_last_r <= rd_req.last;
    if (push) begin
      data_r[wr_idx] <= rd_data;
      last_r[wr_idx] <= pend_last_r;
    end
  end

endmodule
`default_nettype wire

[src/spiral_matrix_reorder.sv]
`default_nettype none
// Spiral matrix reorder.
// Input channel (in_valid/in_ready, in_element_in): matrix elements in row-major
// order, one beat each, one beat per cycle while loading. Elements are written
// into a single-port-write, registered-read element memory.
// Config port (cfg_we, cfg_index, cfg_data): row_count at index 0, column_count
// at index 1, registered on a write; a zero reads as 1, values above the maximum
// are clipped. Write only while the block is idle.
// The beat that completes rows*columns elements starts the spiral: the input
// closes and the walker issues one memory read per cycle while the output
// buffer has room. The first result passes the memory's read register and
// the output buffer before it shows on the output; then one result per cycle
// while out_ready is high, the final one with out_last_out set. The input
// reopens once the last read has gone to the memory. Load and spiral take turns
// on the single memory: one write per load beat, one read per result beat.
// The output side has a two-entry buffer; a low out_ready holds back memory
// reads and no beat is lost. Reset (rst_n, synchronous) clears counters and
// sets both dimensions to 8; memory contents are not cleared.
module spiral_matrix_reorder #(
  parameter int unsigned MAX_ROWS = smr_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = smr_pkg::MAX_COLS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [smr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [smr_pkg::CFG_W-1:0]            cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [smr_pkg::DATA_W-1:0]    in_element_in,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [smr_pkg::DATA_W-1:0]         out_element_out,
  output logic                                      out_last_out
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW = $clog2(MAX_COLS + 1);

  logic [smr_pkg::CFG_W-1:0] row_count_r, column_count_r;
  logic [RW-1:0] rows_eff;
  logic [CW-1:0] cols_eff;

  logic                     wr_en, rd_ok;
  logic [AW-1:0]            wr_addr, rd_addr;
  smr_pkg::rd_req_t         rd_req;
  logic [smr_pkg::DATA_W-1:0] rd_data, out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= smr_pkg::DIM_RESET;
      column_count_r <= smr_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smr_pkg::REG_ROW_COUNT:    row_count_r    <= cfg_data;
        smr_pkg::REG_COLUMN_COUNT: column_count_r <= cfg_data;
      endcase
    end
  end

  // clip dimensions to 1..max
  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = RW'(1);
    end else if (32'(row_count_r) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(row_count_r);
    end
    if (column_count_r == '0) begin
      cols_eff = CW'(1);
    end else if (32'(column_count_r) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(column_count_r);
    end
  end

  smr_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .rows     (rows_eff),
    .cols     (cols_eff),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rd_ok    (rd_ok),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .rd_req   (rd_req),
    .rd_addr  (rd_addr)
  );

  smr_ram #(
    .WIDTH (smr_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_element_in),
    .re    (rd_req.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  smr_ofifo #(
    .WIDTH (smr_pkg::DATA_W)
  ) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_req    (rd_req),
    .rd_data   (rd_data),
    .rd_ok     (rd_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .out_last  (out_last_out)
  );

  assign out_element_out = out_data;

endmodule
`default_nettype wire
